@@ rtl/drcs_pkg.sv @@
// Shared types and constants for the disk request checker and seek unit.
`timescale 1ns / 1ps
`default_nettype none
package drcs_pkg;

   // Field widths of the request, result and configuration registers.
   localparam int DIV_W       = 13;
   localparam int CAP_W       = 36;
   localparam int OFS_W       = 36;
   localparam int LEN_W       = 32;
   localparam int ADDR_W      = 32;
   localparam int CYL_W       = 27;
   localparam int HEAD_W      = 8;
   localparam int TRK_W       = 20;
   localparam int KIND_W      = 2;
   localparam int ERR_W       = 2;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 36;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 96;

   // Request kinds; any other code is treated as an idle event.
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LEN  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_ADDR = 2'd2;

   // Drive modes.
   localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_HEADS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_PROTECT = 3'd4;

   typedef struct packed {
      logic [HEAD_W-1:0] num_heads;
      logic [HEAD_W-1:0] sectors_per_track;
      logic [DIV_W-1:0]  block_size;
      logic [CAP_W-1:0]  capacity_bytes;
      logic              write_protect;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OFS_W-1:0]  byte_offset;
      logic [LEN_W-1:0]  transfer_length;
      logic [ADDR_W-1:0] dma_address;
      logic              start_in_ram;
      logic              end_in_ram;
   } req_type;

   typedef struct packed {
      logic [ERR_W-1:0]  error_code;
      logic [MODE_W-1:0] drive_status;
      logic [CYL_W-1:0]  cylinder_now;
      logic [HEAD_W-1:0] head_now;
      logic [TRK_W-1:0]  track_byte_offset;
      logic              step_event;
      logic              write_done;
      logic              modified_now;
      logic [ADDR_W-1:0] dma_address_out;
      logic              transfer_go;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/drcs_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module drcs_div #(
   parameter int WIDTH = 36
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [WIDTH-1:0]          dividend,
   input  wire logic [drcs_pkg::DIV_W-1:0] divisor,
   output logic                           done,
   output logic [WIDTH-1:0]               quotient,
   output logic [drcs_pkg::DIV_W-1:0]     remainder
);
   import drcs_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);

   logic [DIV_W-1:0] rem_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [DIV_W-1:0] divisor_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // One trial subtraction of the shifted partial remainder.
   logic [DIV_W:0]   partial;
   logic             fits;
   logic [DIV_W:0]   diff;

   always_comb begin
      partial = {rem_ff, quo_ff[WIDTH-1]};
      fits    = partial >= {1'b0, divisor_ff};
      diff    = partial - {1'b0, divisor_ff};
   end

   // Load on start, then shift one dividend bit in per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff     <= '0;
            quo_ff     <= dividend;
            divisor_ff <= divisor;
            cnt_ff     <= '0;
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
            quo_ff <= {quo_ff[WIDTH-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

@@ rtl/drcs_seq.sv @@
// Sequencer that checks a request and positions the head using the shared divider.
`timescale 1ns / 1ps
`default_nettype none
module drcs_seq #(
   parameter int OFFSET_WIDTH = 36,
   parameter int ALIGN_BYTES  = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire drcs_pkg::cfg_type cfg,
   input  wire drcs_pkg::req_type req,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output drcs_pkg::rsp_type      rsp,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready
);
   import drcs_pkg::*;

   localparam int OW   = OFFSET_WIDTH;
   localparam int CAPW = (OW < CAP_W) ? OW : CAP_W;
   localparam int INW  = (OW < OFS_W) ? OW : OFS_W;
   localparam int PW   = DIV_W + HEAD_W;
   // ALIGN_BYTES must be a power of two, which the block does not check; alignment is a check of the low bits.
   localparam int ALIGN_LOG = $clog2(ALIGN_BYTES);

   typedef enum logic [3:0] {
      S_IDLE, S_LEN, S_ALIGN, S_END, S_LBA, S_SEC, S_CYL, S_MUL, S_OUT
   } state_type;

   state_type         state_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [OW-1:0]     ofs_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              ram_ok_ff;
   logic [ERR_W-1:0]  err_ff;
   logic              start_ff;
   logic [OW-1:0]     opa_ff;
   logic [DIV_W-1:0]  opb_ff;
   logic [HEAD_W-1:0] sec_ff;
   logic [CYL_W-1:0]  cyl_ff;
   logic [HEAD_W-1:0] hd_ff;
   logic [TRK_W-1:0]  trk_ff;
   logic [MODE_W-1:0] mode_ff;
   logic              mod_ff;
   logic              step_ff;
   logic              wdone_ff;
   logic              go_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic              div_done;
   logic [OW-1:0]     div_quo;
   logic [DIV_W-1:0]  div_rem;

   drcs_div #(
      .WIDTH(OW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (opa_ff),
      .divisor  (opb_ff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // Geometry divisors, with a zero register dividing as one.
   logic [DIV_W-1:0] bs_nz;
   logic [DIV_W-1:0] secs_nz;
   logic [DIV_W-1:0] heads_nz;
   logic [OW:0]      end_sum;
   logic [OW:0]      cap_ext;
   logic [PW-1:0]    trk_prod;
   logic             is_request;

   always_comb begin
      bs_nz      = (cfg.block_size == '0) ? DIV_W'(1) : cfg.block_size;
      secs_nz    = (cfg.sectors_per_track == '0) ? DIV_W'(1)
                                                 : DIV_W'(cfg.sectors_per_track);
      heads_nz   = (cfg.num_heads == '0) ? DIV_W'(1) : DIV_W'(cfg.num_heads);
      end_sum    = (OW + 1)'(ofs_ff) + (OW + 1)'(len_ff);
      cap_ext    = (OW + 1)'(cfg.capacity_bytes[CAPW-1:0]);
      trk_prod   = PW'(cfg.block_size) * PW'(sec_ff);
      is_request = (req.kind == KIND_READ) || (req.kind == KIND_WRITE);
   end

   // Main sequencer with head state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cyl_ff       <= '0;
         hd_ff        <= '0;
         trk_ff       <= '0;
         mode_ff      <= MODE_IDLE;
         mod_ff       <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         // The output state sets the valid flag itself when it loads a new result.
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff   <= req.kind;
                  ofs_ff    <= OW'(req.byte_offset[INW-1:0]);
                  len_ff    <= req.transfer_length;
                  addr_ff   <= req.dma_address;
                  ram_ok_ff <= req.start_in_ram && req.end_in_ram;
                  err_ff    <= ERR_OK;
                  step_ff   <= 1'b0;
                  wdone_ff  <= 1'b0;
                  go_ff     <= 1'b0;
                  if (is_request) begin
                     state_ff <= S_LEN;
                  end else begin
                     mode_ff  <= MODE_IDLE;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_LEN: begin
               if (len_ff[ALIGN_LOG-1:0] != '0) begin
                  err_ff   <= ERR_LEN;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_ALIGN;
               end
            end
            S_ALIGN: begin
               if (ofs_ff[ALIGN_LOG-1:0] != '0) begin
                  err_ff   <= ERR_ADDR;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_END;
               end
            end
            S_END: begin
               if ((end_sum > cap_ext) || !ram_ok_ff) begin
                  err_ff   <= ERR_ADDR;
                  state_ff <= S_OUT;
               end else begin
                  start_ff <= 1'b1;
                  opa_ff   <= ofs_ff;
                  opb_ff   <= bs_nz;
                  state_ff <= S_LBA;
               end
            end
            S_LBA: begin
               // Quotient is the LBA; divide it by sectors per track.
               if (div_done) begin
                  start_ff <= 1'b1;
                  opa_ff   <= div_quo;
                  opb_ff   <= secs_nz;
                  state_ff <= S_SEC;
               end
            end
            S_SEC: begin
               // Remainder is the sector; the track number goes on to heads.
               if (div_done) begin
                  sec_ff   <= div_rem[HEAD_W-1:0];
                  start_ff <= 1'b1;
                  opa_ff   <= div_quo;
                  opb_ff   <= heads_nz;
                  state_ff <= S_CYL;
               end
            end
            S_CYL: begin
               if (div_done) begin
                  step_ff  <= div_quo[CYL_W-1:0] != cyl_ff;
                  cyl_ff   <= div_quo[CYL_W-1:0];
                  hd_ff    <= div_rem[HEAD_W-1:0];
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               trk_ff <= trk_prod[TRK_W-1:0];
               if (kind_ff == KIND_READ) begin
                  mode_ff <= MODE_READ;
                  go_ff   <= 1'b1;
               end else begin
                  mode_ff <= MODE_WRITE;
                  if (!cfg.write_protect) begin
                     wdone_ff <= 1'b1;
                     go_ff    <= 1'b1;
                     mod_ff   <= 1'b1;
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.error_code        <= err_ff;
                  rsp_ff.drive_status      <= mode_ff;
                  rsp_ff.cylinder_now      <= cyl_ff;
                  rsp_ff.head_now          <= hd_ff;
                  rsp_ff.track_byte_offset <= trk_ff;
                  rsp_ff.step_event        <= step_ff;
                  rsp_ff.write_done        <= wdone_ff;
                  rsp_ff.modified_now      <= mod_ff;
                  rsp_ff.dma_address_out   <= go_ff ? addr_ff : '0;
                  rsp_ff.transfer_go       <= go_ff;
                  rsp_valid_ff             <= 1'b1;
                  state_ff                 <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/disk_request_check_and_chs_seek.sv @@
// A request is checked in turn for a bad length, a misaligned offset and an end past capacity
// or outside RAM; a rejected request stops at its first failed check and goes to the result.
// An idle event goes straight to the result. A request that passes every check makes three
// passes through the one-bit-per-cycle divider (by block size, sectors per track and heads).
// One item at a time; input is ready the cycle after the previous result is registered,
// and a new result waits while the previous one is not yet taken. Reset is synchronous and active high; it
// restores the register defaults and clears the head position, drive mode and modified flag.
`timescale 1ns / 1ps
`default_nettype none
module disk_request_check_and_chs_seek #(
   parameter int OFFSET_WIDTH = 36,
   parameter int ALIGN_BYTES  = 512
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // fields from bit 0: byte_offset, transfer_length, dma_address, start_in_ram, end_in_ram
   input  wire logic [drcs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // fields from bit 0: kind
   input  wire logic [drcs_pkg::KIND_W-1:0]      req_tuser,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: drive_status, cylinder_now, head_now, track_byte_offset,
   // step_event, write_done, modified_now, dma_address_out, transfer_go
   output logic [drcs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // fields from bit 0: error_code
   output logic [drcs_pkg::ERR_W-1:0]            rsp_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [drcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [drcs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import drcs_pkg::*;

   cfg_type cfg_ff;
   req_type req;
   rsp_type rsp;

   // Configuration registers; writes are taken in any cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_heads         <= HEAD_W'(1);
         cfg_ff.sectors_per_track <= HEAD_W'(32);
         cfg_ff.block_size        <= DIV_W'(512);
         cfg_ff.capacity_bytes    <= CAP_W'(10485760);
         cfg_ff.write_protect     <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_HEADS:     cfg_ff.num_heads         <= csr_data[HEAD_W-1:0];
            CSR_SECTORS:       cfg_ff.sectors_per_track <= csr_data[HEAD_W-1:0];
            CSR_BLOCK_SIZE:    cfg_ff.block_size        <= csr_data[DIV_W-1:0];
            CSR_CAPACITY:      cfg_ff.capacity_bytes    <= csr_data[CAP_W-1:0];
            CSR_WRITE_PROTECT: cfg_ff.write_protect     <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Request unpacking.
   always_comb begin
      req.kind            = req_tuser;
      req.byte_offset     = req_tdata[35:0];
      req.transfer_length = req_tdata[67:36];
      req.dma_address     = req_tdata[99:68];
      req.start_in_ram    = req_tdata[100];
      req.end_in_ram      = req_tdata[101];
   end

   drcs_seq #(
      .OFFSET_WIDTH(OFFSET_WIDTH),
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .rsp      (rsp),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready)
   );

   // Result packing.
   assign rsp_tuser = rsp.error_code;
   assign rsp_tdata = {3'b000, rsp.transfer_go, rsp.dma_address_out, rsp.modified_now,
                       rsp.write_done, rsp.step_event, rsp.track_byte_offset,
                       rsp.head_now, rsp.cylinder_now, rsp.drive_status};

`ifndef SYNTHESIS
   // The block is not ready in the cycle after it takes a transaction.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again right after a transaction");

   // The buffer address is only passed on when the transfer proceeds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.transfer_go) |-> (rsp.dma_address_out == '0))
      else $error("buffer address leaked without a transfer");

   // A performed write implies a clean check, a transfer and the sticky flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.write_done) |->
         (rsp.transfer_go && rsp.modified_now && (rsp.error_code == ERR_OK)
          && (rsp.drive_status == MODE_WRITE)))
      else $error("write done without a valid unprotected write");

   // A rejected request neither moves the head nor starts a transfer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp.error_code != ERR_OK)) |->
         (!rsp.step_event && !rsp.transfer_go && !rsp.write_done))
      else $error("rejected request had side effects");
`endif

endmodule
`default_nettype wire

@@ tb/disk_request_check_and_chs_seek_tb.sv @@
// Self-checking testbench for the disk request checker and CHS seek unit.
`timescale 1ns / 1ps
module disk_request_check_and_chs_seek_tb;
   import drcs_pkg::*;

   localparam longint unsigned SECTOR_BYTES = 512;
   localparam int MAX_CYCLES = 2000000;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 125;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES = 600;

   // Kinds that the package leaves unnamed; both act as an idle event.
   localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   // Request word as it sits on req_tdata, most significant field first.
   typedef struct packed {
      logic [1:0]        pad;
      logic              end_in_ram;
      logic              start_in_ram;
      logic [ADDR_W-1:0] dma_address;
      logic [LEN_W-1:0]  transfer_length;
      logic [OFS_W-1:0]  byte_offset;
   } req_word_type;

   // Response word as it sits on rsp_tdata, most significant field first.
   typedef struct packed {
      logic [2:0]        pad;
      logic              transfer_go;
      logic [ADDR_W-1:0] dma_address_out;
      logic              modified_now;
      logic              write_done;
      logic              step_event;
      logic [TRK_W-1:0]  track_byte_offset;
      logic [HEAD_W-1:0] head_now;
      logic [CYL_W-1:0]  cylinder_now;
      logic [MODE_W-1:0] drive_status;
   } rsp_word_type;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [ERR_W-1:0]       rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Shadow of the configuration and of the drive state.
   cfg_type           drive_cfg;
   logic [CYL_W-1:0]  head_cyl;
   logic [HEAD_W-1:0] head_sel;
   logic [TRK_W-1:0]  head_trk;
   logic [MODE_W-1:0] drive_mode;
   logic              modified;

   rsp_type      pending_results[$];
   stim_row_type stim_tab[$];
   int        mismatches = 0;
   int        cycles = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        hold_left = 0;
   longint unsigned last_blk = 0;

   disk_request_check_and_chs_seek dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Works out the result of one request and advances the shadow state.
   function automatic rsp_type chs_seek_result(req_type r);
      longint unsigned ofs = r.byte_offset;
      longint unsigned len = r.transfer_length;
      longint unsigned cap = drive_cfg.capacity_bytes;
      longint unsigned heads, secs, bsz, lba, sec;
      logic [CYL_W-1:0] new_cyl;
      rsp_type o;
      o = '0;
      o.error_code = ERR_OK;
      if (r.kind == KIND_READ || r.kind == KIND_WRITE) begin
         if (len % SECTOR_BYTES != 0) begin
            o.error_code = ERR_LEN;
         end else if (ofs % SECTOR_BYTES != 0 || ofs + len > cap ||
                      !r.start_in_ram || !r.end_in_ram) begin
            o.error_code = ERR_ADDR;
         end
         if (o.error_code == ERR_OK) begin
            drive_mode = (r.kind == KIND_READ) ? MODE_READ : MODE_WRITE;
            // A zero geometry register divides as if it were one.
            heads = (drive_cfg.num_heads == 0) ? 1 : drive_cfg.num_heads;
            secs = (drive_cfg.sectors_per_track == 0) ? 1 : drive_cfg.sectors_per_track;
            bsz = (drive_cfg.block_size == 0) ? 1 : drive_cfg.block_size;
            lba = ofs / bsz;
            new_cyl = CYL_W'(lba / (heads * secs));
            sec = lba % secs;
            o.step_event = (new_cyl != head_cyl);
            head_cyl = new_cyl;
            head_sel = HEAD_W'((lba / secs) % heads);
            head_trk = TRK_W'(drive_cfg.block_size * sec);
            if (r.kind == KIND_READ) begin
               o.transfer_go = 1'b1;
            end else if (!drive_cfg.write_protect) begin
               o.transfer_go = 1'b1;
               o.write_done = 1'b1;
               modified = 1'b1;
            end
         end
      end else begin
         drive_mode = MODE_IDLE;
      end
      o.drive_status = drive_mode;
      o.cylinder_now = head_cyl;
      o.head_now = head_sel;
      o.track_byte_offset = head_trk;
      o.modified_now = modified;
      o.dma_address_out = o.transfer_go ? r.dma_address : '0;
      return o;
   endfunction

   function automatic req_type mk_req(logic [KIND_W-1:0] kind, longint unsigned ofs,
                                      longint unsigned len, logic [ADDR_W-1:0] addr,
                                      bit sa, bit ea);
      req_type r;
      r.kind = kind;
      r.byte_offset = ofs[OFS_W-1:0];
      r.transfer_length = len[LEN_W-1:0];
      r.dma_address = addr;
      r.start_in_ram = sa;
      r.end_in_ram = ea;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [ERR_W-1:0] err, logic [MODE_W-1:0] mode,
                                      int cyl, int head, int trk, bit step, bit wd,
                                      bit md, logic [ADDR_W-1:0] addr, bit go);
      rsp_type o;
      o.error_code = err;
      o.drive_status = mode;
      o.cylinder_now = CYL_W'(cyl);
      o.head_now = HEAD_W'(head);
      o.track_byte_offset = TRK_W'(trk);
      o.step_event = step;
      o.write_done = wd;
      o.modified_now = md;
      o.dma_address_out = addr;
      o.transfer_go = go;
      return o;
   endfunction

   // Appends one row to the stimulus table.
   task automatic add_row(req_type r, bit typed, rsp_type o);
      stim_row_type row;
      row.req = r;
      row.typed = typed;
      row.rsp = o;
      stim_tab.insert(stim_tab.size(), row);
   endtask

   // Mostly well-formed requests inside the drive, then flawed ones, idles and noise.
   function automatic req_type random_request();
      req_type r;
      longint unsigned blocks, ofs_blk, len_max, len_blk;
      int pick;
      blocks = drive_cfg.capacity_bytes / SECTOR_BYTES;
      pick = $urandom_range(0, 99);
      r.kind = KIND_W'($urandom_range(0, 3));
      r.byte_offset = OFS_W'({$urandom, $urandom});
      r.transfer_length = $urandom;
      if ($urandom_range(0, 1)) begin
         r.transfer_length[8:0] = '0;
      end
      r.dma_address = $urandom;
      r.start_in_ram = 1'($urandom_range(0, 1));
      r.end_in_ram = 1'($urandom_range(0, 1));
      if (pick < 10) begin
         return r;
      end
      if (pick < 20) begin
         r.kind = $urandom_range(0, 1) ? KIND_IDLE : KIND_SPARE;
         return r;
      end
      r.kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
      r.start_in_ram = 1'b1;
      r.end_in_ram = 1'b1;
      ofs_blk = 0;
      len_blk = 0;
      if (blocks != 0) begin
         // Staying near the last offset keeps the head on its cylinder.
         if ($urandom_range(0, 3) == 0) begin
            ofs_blk = last_blk + $urandom_range(0, 3);
         end else begin
            ofs_blk = $urandom_range(0, blocks - 1);
         end
         if (ofs_blk >= blocks) begin
            ofs_blk = blocks - 1;
         end
         len_max = blocks - ofs_blk;
         if (len_max > 64'h7F_FFFF) begin
            len_max = 64'h7F_FFFF;
         end
         if ($urandom_range(0, 1)) begin
            len_blk = $urandom_range(0, (len_max < 16) ? len_max : 16);
         end else begin
            len_blk = $urandom_range(0, len_max);
         end
      end
      last_blk = ofs_blk;
      r.byte_offset = OFS_W'(ofs_blk * SECTOR_BYTES);
      r.transfer_length = LEN_W'(len_blk * SECTOR_BYTES);
      // Broken requests: one flaw each.
      if (pick >= 85) begin
         case ($urandom_range(0, 4))
            0: r.transfer_length = r.transfer_length + $urandom_range(1, 511);
            1: r.byte_offset = r.byte_offset + $urandom_range(1, 511);
            2: r.start_in_ram = 1'b0;
            3: r.end_in_ram = 1'b0;
            default: begin
               r.byte_offset = OFS_W'(blocks * SECTOR_BYTES);
               r.transfer_length = LEN_W'(SECTOR_BYTES);
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   // Writes one register and mirrors it into the shadow configuration.
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUM_HEADS:     drive_cfg.num_heads = val[HEAD_W-1:0];
         CSR_SECTORS:       drive_cfg.sectors_per_track = val[HEAD_W-1:0];
         CSR_BLOCK_SIZE:    drive_cfg.block_size = val[DIV_W-1:0];
         CSR_CAPACITY:      drive_cfg.capacity_bytes = val[CAP_W-1:0];
         CSR_WRITE_PROTECT: drive_cfg.write_protect = val[0];
         default: ;
      endcase
   endtask

   // Offers one request, with random idle cycles ahead of it, and records its result.
   task automatic offer_request(req_type r, bit typed, rsp_type typed_rsp);
      req_word_type w;
      rsp_type predicted;
      w = '0;
      w.byte_offset = r.byte_offset;
      w.transfer_length = r.transfer_length;
      w.dma_address = r.dma_address;
      w.start_in_ram = r.start_in_ram;
      w.end_in_ram = r.end_in_ram;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = w;
      req_tuser = r.kind;
      do @(posedge clock); while (!req_tready);
      predicted = chs_seek_result(r);
      pending_results.insert(pending_results.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Result ready: random stalls, or a long hold-off while hold_left runs down.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Compares each result transaction with the oldest pending expectation.
   initial begin
      rsp_word_type w;
      rsp_type want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            w = rsp_tdata;
            if (pending_results.size() == 0) begin
               report_mismatch("result transaction with no request pending");
            end else begin
               want = pending_results.pop_front();
               check_field("error_code", rsp_tuser, want.error_code);
               check_field("drive_status", w.drive_status, want.drive_status);
               check_field("cylinder_now", w.cylinder_now, want.cylinder_now);
               check_field("head_now", w.head_now, want.head_now);
               check_field("track_byte_offset", w.track_byte_offset, want.track_byte_offset);
               check_field("step_event", w.step_event, want.step_event);
               check_field("write_done", w.write_done, want.write_done);
               check_field("modified_now", w.modified_now, want.modified_now);
               check_field("dma_address_out", w.dma_address_out, want.dma_address_out);
               check_field("transfer_go", w.transfer_go, want.transfer_go);
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycles < MAX_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("disk_request_check_and_chs_seek regression: fail");
      $finish;
   end

   initial begin
      cfg_type pc;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      drive_cfg.num_heads = 8'd1;
      drive_cfg.sectors_per_track = 8'd32;
      drive_cfg.block_size = 13'd512;
      drive_cfg.capacity_bytes = 36'd10485760;
      drive_cfg.write_protect = 1'b0;
      head_cyl = '0;
      head_sel = '0;
      head_trk = '0;
      drive_mode = MODE_IDLE;
      modified = 1'b0;

      // Directed requests against the reset geometry (10 MiB, one head, 32 sectors).
      add_row(mk_req(KIND_IDLE, 0, 0, 0, 0, 0), 1'b1,
              mk_rsp(ERR_OK, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(KIND_READ, 0, 1, 32'hFFFF_FFFF, 1, 1), 1'b1,
              mk_rsp(ERR_LEN, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(KIND_WRITE, 0, 'h1FF, 32'h1, 1, 1), 1'b1,
              mk_rsp(ERR_LEN, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(KIND_READ, 1, 512, 32'h2, 1, 1), 1'b1,
              mk_rsp(ERR_ADDR, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0));
      // End one sector past the capacity.
      add_row(mk_req(KIND_READ, 'h9F_FE00, 1024, 32'h3, 1, 1), 1'b1,
              mk_rsp(ERR_ADDR, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(KIND_READ, 0, 512, 32'h4, 0, 1), 1'b1,
              mk_rsp(ERR_ADDR, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(KIND_WRITE, 0, 512, 32'h5, 1, 0), 1'b1,
              mk_rsp(ERR_ADDR, MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(KIND_READ, 0, 0, 32'hFFFF_FFFF, 1, 1), 1'b1,
              mk_rsp(ERR_OK, MODE_READ, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1));
      add_row(mk_req(KIND_WRITE, 512, 512, 32'h1234_5678, 1, 1), 1'b1,
              mk_rsp(ERR_OK, MODE_WRITE, 0, 0, 512, 0, 1, 1, 32'h1234_5678, 1));
      // The unnamed fourth kind behaves as an idle event.
      add_row(mk_req(KIND_SPARE, 0, 0, 32'hFFFF_FFFF, 1, 1), 1'b1,
              mk_rsp(ERR_OK, MODE_IDLE, 0, 0, 512, 0, 0, 1, 0, 0));
      // The rest are left to the predictor.
      add_row(mk_req(KIND_READ, 'h9F_FE00, 512, 32'hA5A5_A5A5, 1, 1), 1'b0, '0);
      add_row(mk_req(KIND_WRITE, 'hF_FFFF_FFFF, 'hFFFF_FFFF, 32'h0, 1, 1), 1'b0, '0);
      add_row(mk_req(KIND_READ, 'hF_FFFF_FE00, 0, 32'h7, 1, 1), 1'b0, '0);
      add_row(mk_req(KIND_WRITE, 'h12_3400, 'h4000, 32'h5A5A_5A5A, 1, 1), 1'b0, '0);
      add_row(mk_req(KIND_READ, 0, 'hA0_0000, 32'h8, 1, 1), 1'b0, '0);
      add_row(mk_req(KIND_READ, 0, 'hFFFF_FE00, 32'h9, 1, 1), 1'b0, '0);
      add_row(mk_req(KIND_WRITE, 'h9F_FE00, 512, 32'hA, 0, 0), 1'b0, '0);
      add_row(mk_req(KIND_IDLE, 'hF_FFFF_FFFF, 0, 32'hB, 1, 1), 1'b0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_tab[i]) begin
         offer_request(stim_tab[i].req, stim_tab[i].typed, stim_tab[i].rsp);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();

      // Random phases, each with its own geometry and one of four idling patterns.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: pc = '{8'd255, 8'd255, 13'd4096, 36'hF_FFFF_FFFF, 1'b1};
            1: pc = '{8'd1, 8'd1, 13'd256, 36'd0, 1'b0};
            2: pc = '{8'd0, 8'd0, 13'd0, 36'hF_FFFF_FFFF, 1'b0};
            3: pc = '{HEAD_W'($urandom_range(1, 255)), 8'd255, 13'h1FFF, 36'hF_FFFF_FFFF,
                      1'($urandom_range(0, 1))};
            default: begin
               pc.num_heads = HEAD_W'($urandom_range(1, 255));
               pc.sectors_per_track = HEAD_W'($urandom_range(1, 255));
               pc.block_size = DIV_W'($urandom_range(256, 4096));
               if (p % 2 == 0) begin
                  pc.capacity_bytes = CAP_W'({$urandom, $urandom});
               end else begin
                  pc.capacity_bytes = CAP_W'($urandom_range(0, 32'h0400_0000));
               end
               pc.write_protect = 1'($urandom_range(0, 1));
            end
         endcase
         csr_write(CSR_NUM_HEADS, CSR_DATA_W'(pc.num_heads));
         csr_write(CSR_SECTORS, CSR_DATA_W'(pc.sectors_per_track));
         csr_write(CSR_BLOCK_SIZE, CSR_DATA_W'(pc.block_size));
         csr_write(CSR_CAPACITY, pc.capacity_bytes);
         csr_write(CSR_WRITE_PROTECT, CSR_DATA_W'(pc.write_protect));
         @(negedge clock);
         csr_valid = 1'b0;

         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         // Hold the result side off so the block backs up into its input.
         if (p == 0 || p == 5) begin
            hold_left = HOLD_CYCLES;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            offer_request(random_request(), 1'b0, '0);
         end
         @(negedge clock);
         req_tvalid = 1'b0;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("disk_request_check_and_chs_seek regression: pass");
      end else begin
         $display("disk_request_check_and_chs_seek regression: fail");
      end
      $finish;
   end

endmodule
